@@ hdl/sjfq_pkg.sv @@
// types, codes and control bundles shared by the shortest-job-first queue
`timescale 1ns / 1ps
`default_nettype none

package sjfq_pkg;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] duration;
      logic [2:0]  priority_lvl;
   } entry_type;

   typedef struct packed {
      logic load;
      logic scan_rd;
      logic scan_end;
      logic copy_rd;
      logic commit;
      logic reply;
   } dp_cmd_type;

   typedef struct packed {
      logic start_scan;
      logic scan_last;
      logic copy_done;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ hdl/sjfq_datapath.sv @@
// queue memory, pointers, minimum search and response register
`timescale 1ns / 1ps
`default_nettype none

module sjfq_datapath import sjfq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_cmd_type    cmd,
   output dp_status_type      status,
   input  wire logic          req_cmd,
   input  wire logic [7:0]    req_job_id,
   input  wire logic [15:0]   req_job_duration,
   input  wire logic [2:0]    req_job_priority,
   input  wire logic          rsp_stall,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_out_id,
   output logic [15:0]        rsp_out_duration,
   output logic [2:0]         rsp_out_priority,
   output logic [4:0]         rsp_jobs_left
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == LAST_PTR) ? '0 : p + PW'(1);
   endfunction

   entry_type mem [QUEUE_DEPTH];

   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] scan_ptr_ff, scan_ptr_in, scan_idx_ff, scan_idx_in, scan_i_ff;
   logic [PW-1:0] src_ptr_ff, src_ptr_in, dst_ptr_ff, dst_ptr_in;
   logic [PW-1:0] copy_idx_ff, copy_idx_in, pick_ff, pick_in;
   logic          scan_v_ff, cp_v_ff;
   entry_type     best_ff, best_in, rd_data_ff;
   logic [1:0]    res_status_ff, res_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff;
   entry_type     rsp_entry_ff;
   logic [4:0]    rsp_jobs_ff;

   logic          full, empty, is_pop, push_ok;
   logic          wr_en;
   logic [PW-1:0] wr_addr, rd_addr;
   entry_type     wr_data;
   logic [CW+4:0] count_wide;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign is_pop  = (req_cmd == CMD_POP);
   assign push_ok = cmd.load && !is_pop && !full;
   assign count_wide = {5'd0, count_ff};

   assign status.start_scan = is_pop && !empty;
   assign status.scan_last  = (CW'(scan_idx_ff) == count_ff - CW'(1));
   assign status.copy_done  = (copy_idx_ff == pick_ff);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      scan_ptr_in   = scan_ptr_ff;
      scan_idx_in   = scan_idx_ff;
      src_ptr_in    = src_ptr_ff;
      dst_ptr_in    = dst_ptr_ff;
      copy_idx_in   = copy_idx_ff;
      pick_in       = pick_ff;
      best_in       = best_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (cmd.load) begin
         scan_ptr_in = head_ff;
         scan_idx_in = '0;
         if (!is_pop) begin
            res_status_in = full ? ST_FULL : ST_OK;
         end else begin
            res_status_in = empty ? ST_EMPTY : ST_OK;
         end
         if (!(is_pop && !empty)) begin
            best_in = '0;
         end
         if (push_ok) begin
            tail_in  = next_ptr(tail_ff);
            count_in = count_ff + CW'(1);
         end
      end

      if (cmd.scan_rd) begin
         scan_ptr_in = next_ptr(scan_ptr_ff);
         scan_idx_in = scan_idx_ff + PW'(1);
      end

      if (scan_v_ff && (scan_i_ff == '0 || rd_data_ff.duration < best_ff.duration)) begin
         best_in = rd_data_ff;
         pick_in = scan_i_ff;
      end

      if (cmd.scan_end) begin
         src_ptr_in  = head_ff;
         dst_ptr_in  = tail_ff;
         copy_idx_in = '0;
      end

      if (cmd.copy_rd) begin
         src_ptr_in  = next_ptr(src_ptr_ff);
         copy_idx_in = copy_idx_ff + PW'(1);
      end

      if (cp_v_ff) begin
         dst_ptr_in = next_ptr(dst_ptr_ff);
      end

      if (cmd.commit) begin
         head_in  = next_ptr(src_ptr_ff);
         tail_in  = dst_ptr_ff;
         count_in = count_ff - CW'(1);
      end

      if (cmd.reply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // rotated entries land behind the tail, one word per cycle
   assign wr_en   = push_ok || cp_v_ff;
   assign wr_addr = cp_v_ff ? dst_ptr_ff : tail_ff;
   assign wr_data = cp_v_ff ? rd_data_ff : entry_type'{req_job_id, req_job_duration,
                                                        req_job_priority};
   assign rd_addr = cmd.scan_rd ? scan_ptr_ff : src_ptr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.scan_rd || cmd.copy_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         scan_v_ff    <= 1'b0;
         cp_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         scan_v_ff    <= cmd.scan_rd;
         cp_v_ff      <= cmd.copy_rd;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff   <= scan_ptr_in;
      scan_idx_ff   <= scan_idx_in;
      scan_i_ff     <= scan_idx_ff;
      src_ptr_ff    <= src_ptr_in;
      dst_ptr_ff    <= dst_ptr_in;
      copy_idx_ff   <= copy_idx_in;
      pick_ff       <= pick_in;
      best_ff       <= best_in;
      res_status_ff <= res_status_in;
      if (cmd.reply) begin
         rsp_status_ff <= res_status_ff;
         rsp_entry_ff  <= best_ff;
         rsp_jobs_ff   <= count_wide[4:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_id       = rsp_entry_ff.id;
   assign rsp_out_duration = rsp_entry_ff.duration;
   assign rsp_out_priority = rsp_entry_ff.priority_lvl;
   assign rsp_jobs_left    = rsp_jobs_ff;

endmodule

`default_nettype wire

@@ hdl/sjfq_controller.sv @@
// sequencer for push, minimum scan, rotation copy and reply
`timescale 1ns / 1ps
`default_nettype none

module sjfq_controller import sjfq_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_END,
      S_COPY,
      S_COMMIT,
      S_REPLY
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = status.start_scan ? S_SCAN : S_REPLY;
            end
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            cmd.scan_end = 1'b1;
            state_in     = S_COPY;
         end
         S_COPY: begin
            cmd.copy_rd = !status.copy_done;
            if (status.copy_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_REPLY;
         end
         S_REPLY: begin
            cmd.reply = status.rsp_free;
            if (status.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/shortest_job_first_queue.sv @@
// Shortest-job-first queue: holds up to QUEUE_DEPTH jobs in a circular buffer
// in one memory with one read and one write port. A push, or a pop on an empty
// queue, goes from acceptance straight to the reply state, which registers the
// response word. On a successful pop, with n queued jobs and the shortest job p
// places from the head, the memory read port scans all n entries for the first
// minimum, then copies the p jobs ahead of it behind the tail one word per
// cycle before the head pointer moves past the picked job.
// One request word is worked on at a time; the next is taken while a finished
// response word still waits on rsp_stall.
`timescale 1ns / 1ps
`default_nettype none

module shortest_job_first_queue import sjfq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd,
   input  wire logic [7:0]  req_job_id,
   input  wire logic [15:0] req_job_duration,
   input  wire logic [2:0]  req_job_priority,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_out_id,
   output logic [15:0]      rsp_out_duration,
   output logic [2:0]       rsp_out_priority,
   output logic [4:0]       rsp_jobs_left
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   sjfq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   sjfq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .req_cmd          (req_cmd),
      .req_job_id       (req_job_id),
      .req_job_duration (req_job_duration),
      .req_job_priority (req_job_priority),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_duration (rsp_out_duration),
      .rsp_out_priority (rsp_out_priority),
      .rsp_jobs_left    (rsp_jobs_left)
   );

endmodule

`default_nettype wire

@@ hdl/sjfq_checker.sv @@
// port-level checks on the shortest-job-first queue and their bind
`timescale 1ns / 1ps
`default_nettype none

module sjfq_checker import sjfq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic [7:0]  rsp_out_id,
   input wire logic [15:0] rsp_out_duration,
   input wire logic [2:0]  rsp_out_priority,
   input wire logic [4:0]  rsp_jobs_left
);

   localparam logic [4:0] FULL_JOBS = 5'(QUEUE_DEPTH);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_out_id)
         && $stable(rsp_out_duration) && $stable(rsp_out_priority) && $stable(rsp_jobs_left))
      else $error("stalled response word changed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_out_id == 8'd0 && rsp_out_duration == 16'd0 && rsp_out_priority == 3'd0)
      else $error("failed command returned job fields");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_jobs_left == FULL_JOBS)
      else $error("full status with queue not full");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_jobs_left == 5'd0)
      else $error("empty status with jobs left");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response word after reset");

endmodule

bind shortest_job_first_queue sjfq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_sjfq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_out_id       (rsp_out_id),
   .rsp_out_duration (rsp_out_duration),
   .rsp_out_priority (rsp_out_priority),
   .rsp_jobs_left    (rsp_jobs_left)
);

`default_nettype wire
